// File: rtl/core/dns_a_query_redirect_responder_top_macros.svh
// Assertion macros shared by the responder RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef DNS_A_QUERY_REDIRECT_RESPONDER_TOP_MACROS_SVH
`define DNS_A_QUERY_REDIRECT_RESPONDER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DNSR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dnsr: check failed");
// next-cycle implication
`define DNSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dnsr: check failed");
`else
`define DNSR_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define DNSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/dnsr_pkg.sv
// Types, constants and the answer-record table of the DNS A responder.
// No dependencies.
`default_nettype none
package dnsr_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       run_last;
        logic       frame_end;
        logic       frame_good;
    } out_rsp_t;

    // one classified request byte, handed from front to back
    typedef struct packed {
        logic [7:0] byte_val;
        logic       has_byte;
        logic       answer;
        logic       fend;
        logic       good;
    } cmd_t;

    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic REG_IPV4_ADDRESS  = 1'b0;
    localparam logic REG_ADDRESS_VALID = 1'b1;

    localparam logic [7:0] FLAG_QR_AA     = 8'h84;
    localparam logic [7:0] OPCODE_MASK    = 8'h78;
    localparam logic [7:0] LABEL_MAX      = 8'd63;
    localparam logic [7:0] TTL_SECONDS    = 8'd30;
    localparam int         HEADER_LAST    = 11;
    localparam int         ANSWER_BYTES   = 16;

    // back-end step codes: request byte, answer bytes 1..16, frame-end marker
    localparam logic [4:0] STEP_BYTE   = 5'd0;
    localparam logic [4:0] STEP_ANS_LO = 5'd1;
    localparam logic [4:0] STEP_ANS_HI = 5'd16;
    localparam logic [4:0] STEP_MARK   = 5'd17;

    function automatic logic [7:0] answer_byte(input logic [3:0] idx, input logic [31:0] addr);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'hC0;
            4'd1:    b = 8'h0C;
            4'd3:    b = 8'h01;
            4'd5:    b = 8'h01;
            4'd9:    b = TTL_SECONDS;
            4'd11:   b = 8'h04;
            4'd12:   b = addr[31:24];
            4'd13:   b = addr[23:16];
            4'd14:   b = addr[15:8];
            4'd15:   b = addr[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/dnsr_front.sv
// Front end: accepts request bytes, parses header/question, classifies each byte.
// Depends on dnsr_pkg.
`default_nettype none
module dnsr_front #(
    parameter int MAX_PACKET_BYTES = 512
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  accept,
    input  dnsr_pkg::in_req_t    req,
    input  wire                  addr_valid,
    output dnsr_pkg::cmd_t       cmd,
    output logic                 push
);

    localparam logic [2:0] PH_HEADER     = 3'd0;
    localparam logic [2:0] PH_LABEL_LEN  = 3'd1;
    localparam logic [2:0] PH_LABEL_BODY = 3'd2;
    localparam logic [2:0] PH_TYPE_CLASS = 3'd3;
    localparam logic [2:0] PH_IDLE       = 3'd4;

    localparam logic [9:0]  MAX_POS   = 10'(MAX_PACKET_BYTES);
    localparam logic [10:0] MAX_REPLY = 11'(MAX_PACKET_BYTES);
    localparam logic [10:0] REPLY_ADD = 11'(dnsr_pkg::ANSWER_BYTES + 1);

    logic [2:0] phase_reg, phase_next;
    logic [9:0] pos_reg, pos_next;
    logic [5:0] lbl_reg, lbl_next;
    logic [1:0] tci_reg, tci_next;
    logic       err_reg, err_next;
    logic       qnz_reg, qnz_next;
    logic       done_reg, done_next;

    logic [7:0] b;
    logic [5:0] lbl_dec;

    assign b       = req.in_byte;
    assign lbl_dec = lbl_reg - 6'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        lbl_next     = lbl_reg;
        tci_next     = tci_reg;
        err_next     = err_reg | (pos_reg >= MAX_POS);
        qnz_next     = qnz_reg;
        done_next    = done_reg;
        pos_next     = (pos_reg != '1) ? pos_reg + 10'd1 : pos_reg;
        cmd          = '0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                cmd.has_byte = 1'b1;
                cmd.byte_val = b;
                if (pos_reg == 10'd2)
                begin
                    err_next     = err_next | ((b & dnsr_pkg::OPCODE_MASK) != 8'h00);
                    cmd.byte_val = b | dnsr_pkg::FLAG_QR_AA;
                end
                else if (pos_reg == 10'd4 || pos_reg == 10'd5)
                begin
                    qnz_next     = qnz_next | (b != 8'h00);
                    cmd.byte_val = {7'd0, pos_reg == 10'd5};
                end
                else if (pos_reg == 10'd7)
                    cmd.byte_val = 8'h01;
                else if (pos_reg == 10'd6 || pos_reg >= 10'd8)
                    cmd.byte_val = 8'h00;
                if (pos_reg >= 10'(dnsr_pkg::HEADER_LAST))
                    phase_next = PH_LABEL_LEN;
            end
            PH_LABEL_LEN:
            begin
                if (b > dnsr_pkg::LABEL_MAX)
                begin
                    err_next   = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    cmd.has_byte = 1'b1;
                    cmd.byte_val = b;
                    if (b == 8'h00)
                    begin
                        phase_next = PH_TYPE_CLASS;
                        tci_next   = 2'd0;
                    end
                    else
                    begin
                        lbl_next   = b[5:0];
                        phase_next = PH_LABEL_BODY;
                    end
                end
            end
            PH_LABEL_BODY:
            begin
                cmd.has_byte = 1'b1;
                cmd.byte_val = b;
                lbl_next     = lbl_dec;
                if (lbl_dec == 6'd0)
                    phase_next = PH_LABEL_LEN;
            end
            PH_TYPE_CLASS:
            begin
                // expected type/class bytes: 00 01 00 01
                cmd.has_byte = 1'b1;
                cmd.byte_val = b;
                if (b != {7'd0, tci_reg[0]})
                    err_next = 1'b1;
                if (tci_reg == 2'd3)
                begin
                    if (({1'b0, pos_reg} + REPLY_ADD) > MAX_REPLY)
                        err_next = 1'b1;
                    cmd.answer = 1'b1;
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                    tci_next   = 2'd0;
                end
                else
                    tci_next = tci_reg + 2'd1;
            end
            default:
                phase_next = PH_IDLE;
        endcase

        if (req.in_last)
        begin
            cmd.fend   = 1'b1;
            cmd.good   = ~err_next & done_next & qnz_next & addr_valid;
            phase_next = PH_HEADER;
            pos_next   = '0;
            lbl_next   = '0;
            tci_next   = '0;
            err_next   = 1'b0;
            qnz_next   = 1'b0;
            done_next  = 1'b0;
        end
    end

    assign push = accept & (cmd.has_byte | cmd.fend);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            lbl_reg   <= '0;
            tci_reg   <= '0;
            err_reg   <= 1'b0;
            qnz_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            lbl_reg   <= lbl_next;
            tci_reg   <= tci_next;
            err_reg   <= err_next;
            qnz_reg   <= qnz_next;
            done_reg  <= done_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/dnsr_queue.sv
// Short command queue between parser front end and reply back end.
// Depends on dnsr_pkg and the assertion macro header.
`default_nettype none
`include "dns_a_query_redirect_responder_top_macros.svh"
module dnsr_queue (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  dnsr_pkg::cmd_t  wr_cmd,
    input  wire             pop,
    output dnsr_pkg::cmd_t  rd_cmd,
    output logic            empty,
    output logic            full
);

    localparam int PW = $clog2(dnsr_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(dnsr_pkg::QUEUE_DEPTH + 1);

    dnsr_pkg::cmd_t entry_reg [dnsr_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg, count_next;

    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CW'(dnsr_pkg::QUEUE_DEPTH));
    assign rd_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(dnsr_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(dnsr_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + PW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

    `DNSR_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !full || pop)
    `DNSR_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, !empty)

endmodule
`default_nettype wire

// File: rtl/core/dnsr_back.sv
// Back end: expands queued commands into reply bytes, answer record and frame marker.
// Depends on dnsr_pkg and the assertion macro header.
`default_nettype none
`include "dns_a_query_redirect_responder_top_macros.svh"
module dnsr_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  dnsr_pkg::cmd_t      head,
    input  wire                 empty,
    input  wire  [31:0]         ipv4_address,
    output logic                pop,
    output logic                out_valid,
    input  wire                 out_ready,
    output dnsr_pkg::out_rsp_t  out_data
);

    logic [4:0]         step_reg, step_next;
    logic [4:0]         eff_step;
    logic [4:0]         nstep;
    logic [4:0]         ans_idx;
    logic               last_res;
    logic               load;
    logic               out_valid_reg;
    dnsr_pkg::out_rsp_t rsp;
    dnsr_pkg::out_rsp_t out_data_reg;

    // step_reg == 0 means the head command has not produced anything yet
    assign eff_step = (step_reg != 5'd0) ? step_reg :
                      (head.has_byte ? dnsr_pkg::STEP_BYTE : dnsr_pkg::STEP_MARK);
    assign ans_idx  = eff_step - dnsr_pkg::STEP_ANS_LO;
    assign load     = ~empty & (~out_valid_reg | out_ready);
    assign pop      = load & last_res;

    always_comb
    begin
        nstep    = eff_step + 5'd1;
        last_res = 1'b0;
        rsp      = '0;
        unique case (eff_step)
            dnsr_pkg::STEP_BYTE:
            begin
                rsp.out_byte     = head.byte_val;
                rsp.byte_present = 1'b1;
                if (head.answer)
                    nstep = dnsr_pkg::STEP_ANS_LO;
                else if (head.fend)
                    nstep = dnsr_pkg::STEP_MARK;
                else
                    last_res = 1'b1;
            end
            dnsr_pkg::STEP_ANS_HI:
            begin
                rsp.out_byte     = dnsr_pkg::answer_byte(ans_idx[3:0], ipv4_address);
                rsp.byte_present = 1'b1;
                nstep            = dnsr_pkg::STEP_MARK;
                last_res         = ~head.fend;
            end
            dnsr_pkg::STEP_MARK:
            begin
                rsp.frame_end  = 1'b1;
                rsp.frame_good = head.good;
                last_res       = 1'b1;
            end
            default:
            begin
                rsp.out_byte     = dnsr_pkg::answer_byte(ans_idx[3:0], ipv4_address);
                rsp.byte_present = 1'b1;
            end
        endcase
        rsp.run_last = last_res;
        step_next    = last_res ? 5'd0 : nstep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                step_reg <= step_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= rsp;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `DNSR_ASSERT_NOW(a_marker_closes, clk, rst_n, out_valid_reg && out_data_reg.frame_end,
        !out_data_reg.byte_present && out_data_reg.run_last)
    `DNSR_ASSERT_NOW(a_step_range, clk, rst_n, 1'b1, step_reg <= dnsr_pkg::STEP_MARK)
    `DNSR_ASSERT_NEXT(a_pop_resets_step, clk, rst_n, pop, step_reg == 5'd0)

endmodule
`default_nettype wire

// File: rtl/core/dns_a_query_redirect_responder_top.sv
// Top level of the DNS A-record redirect responder: config registers and wiring.
// Depends on dnsr_pkg, dnsr_front, dnsr_queue and dnsr_back.
`default_nettype none
// The responder takes one DNS request byte per cycle while in_ready is high
// and returns the reply bytes in request order, followed on the last request
// byte by a frame-end marker whose frame_good bit says whether the reply may
// be sent. The parser front end classifies a byte in the cycle it is accepted
// and posts a command to a four-entry queue; the back end drains the queue
// through a registered output stage at one result per cycle unless out_ready
// stalls it. An ordinary request byte yields one result. The final class byte
// of the question expands to 17 results (18 if it is also the last byte). Its
// command holds a queue slot until its last result, so up to three further
// commands fit meanwhile (of the trailing request bytes after the question,
// only the last posts one, for the frame-end marker), after which in_ready
// drops until the answer burst drains. Commands are registered in the queue,
// results in the output register. Configuration writes take effect on the
// next cycle and must only be issued while no request is in flight.
module dns_a_query_redirect_responder_top #(
    parameter int MAX_PACKET_BYTES = 512
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  dnsr_pkg::in_req_t   in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output dnsr_pkg::out_rsp_t  out_data,
    input  wire                 cfg_wr_en,
    input  wire                 cfg_index,
    input  wire  [31:0]         cfg_data
);

    logic [31:0]    ipv4_address_reg;
    logic           address_valid_reg;
    logic           accept;
    logic           push;
    logic           pop;
    logic           empty;
    logic           full;
    dnsr_pkg::cmd_t front_cmd;
    dnsr_pkg::cmd_t head_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ipv4_address_reg  <= '0;
            address_valid_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                dnsr_pkg::REG_IPV4_ADDRESS:  ipv4_address_reg  <= cfg_data;
                dnsr_pkg::REG_ADDRESS_VALID: address_valid_reg <= cfg_data[0];
                default:                     address_valid_reg <= address_valid_reg;
            endcase
        end
    end

    assign in_ready = ~full;
    assign accept   = in_valid & in_ready;

    dnsr_front #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req        (in_data),
        .addr_valid (address_valid_reg),
        .cmd        (front_cmd),
        .push       (push)
    );

    dnsr_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (front_cmd),
        .pop    (pop),
        .rd_cmd (head_cmd),
        .empty  (empty),
        .full   (full)
    );

    dnsr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_cmd),
        .empty        (empty),
        .ipv4_address (ipv4_address_reg),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the DNS A-record redirect responder: query frames go in
// byte by byte, a scoreboard class predicts the reply stream and checks it.
// Depends on dnsr_pkg and dns_a_query_redirect_responder_top.

import dnsr_pkg::*;

localparam int         MAX_BYTES     = 512;
localparam logic [7:0] OPCODE_BITS   = 8'h78;
localparam logic [7:0] QR_AA_BITS    = 8'h84;
localparam int         LONGEST_LABEL = 63;
localparam logic [7:0] ANSWER_TTL    = 8'd30;
localparam int         HEADER_END    = 11;
localparam int         ANSWER_LEN    = 16;
localparam int         SHOWN_ERRORS  = 10;

class reply_scoreboard;
    typedef enum bit [2:0] {ST_HEADER, ST_LABEL_LEN, ST_LABEL_BODY, ST_QTYPE, ST_SKIP} parse_e;

    out_rsp_t    expected_q[$];
    logic [31:0] address;
    bit          address_ok;
    bit [9:0]    position;
    parse_e      state;
    bit [5:0]    label_left;
    bit          bad;
    bit          has_question;
    bit          question_seen;
    bit [1:0]    qtype_idx;
    int          errors;
    int          replies;

    function new();
        address    = '0;
        address_ok = 1'b0;
        errors     = 0;
        replies    = 0;
        restart();
    endfunction

    function void restart();
        position      = '0;
        state         = ST_HEADER;
        label_left    = '0;
        bad           = 1'b0;
        has_question  = 1'b0;
        question_seen = 1'b0;
        qtype_idx     = '0;
    endfunction

    function void set_register(logic idx, logic [31:0] value);
        if (idx == REG_IPV4_ADDRESS)
            address = value;
        else
            address_ok = value[0];
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void push(logic [7:0] value, bit present, bit fend, bit good);
        out_rsp_t r;
        r.out_byte     = value;
        r.byte_present = present;
        r.run_last     = 1'b0;
        r.frame_end    = fend;
        r.frame_good   = good;
        expected_q.push_back(r);
    endfunction

    // works out every reply result that one accepted request causes
    function void note_request(in_req_t req);
        int           first;
        logic [7:0]   b;
        logic [7:0]   o;
        logic [127:0] answer;
        out_rsp_t     tail;
        first = expected_q.size();
        b = req.in_byte;
        if (position >= MAX_BYTES)
            bad = 1'b1;
        case (state)
            ST_HEADER:
            begin
                o = b;
                if (position == 2)
                begin
                    if ((b & OPCODE_BITS) != 0)
                        bad = 1'b1;
                    o = b | QR_AA_BITS;
                end
                else if (position == 4 || position == 5)
                begin
                    if (b != 0)
                        has_question = 1'b1;
                    o = (position == 5) ? 8'd1 : 8'd0;
                end
                else if (position == 7)
                    o = 8'd1;
                else if (position >= 6)
                    o = 8'd0;
                push(o, 1'b1, 1'b0, 1'b0);
                if (position >= HEADER_END)
                    state = ST_LABEL_LEN;
            end
            ST_LABEL_LEN:
            begin
                // oversized label: nothing more is echoed for this frame
                if (b > LONGEST_LABEL)
                begin
                    bad = 1'b1;
                    state = ST_SKIP;
                end
                else
                begin
                    push(b, 1'b1, 1'b0, 1'b0);
                    if (b == 0)
                    begin
                        state = ST_QTYPE;
                        qtype_idx = '0;
                    end
                    else
                    begin
                        label_left = b[5:0];
                        state = ST_LABEL_BODY;
                    end
                end
            end
            ST_LABEL_BODY:
            begin
                push(b, 1'b1, 1'b0, 1'b0);
                label_left = label_left - 6'd1;
                if (label_left == 0)
                    state = ST_LABEL_LEN;
            end
            ST_QTYPE:
            begin
                // type A, class IN: 00 01 00 01
                if (b != {7'd0, qtype_idx[0]})
                    bad = 1'b1;
                push(b, 1'b1, 1'b0, 1'b0);
                if (qtype_idx == 2'd3)
                begin
                    if (int'(position) + 1 + ANSWER_LEN > MAX_BYTES)
                        bad = 1'b1;
                    answer = {8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01,
                              8'h00, 8'h00, 8'h00, ANSWER_TTL, 8'h00, 8'h04, address};
                    for (int i = 0; i < ANSWER_LEN; i++)
                        push(answer[127 - 8 * i -: 8], 1'b1, 1'b0, 1'b0);
                    question_seen = 1'b1;
                    state = ST_SKIP;
                    qtype_idx = '0;
                end
                else
                    qtype_idx = qtype_idx + 2'd1;
            end
            default:
                state = ST_SKIP;
        endcase
        if (position != 10'd1023)
            position = position + 10'd1;
        if (req.in_last)
        begin
            push(8'h00, 1'b0, 1'b1,
                 !bad && question_seen && has_question && address_ok);
            restart();
        end
        if (expected_q.size() > first)
        begin
            tail = expected_q.pop_back();
            tail.run_last = 1'b1;
            expected_q.push_back(tail);
        end
    endfunction

    function string show(out_rsp_t r);
        return $sformatf("byte=%02h present=%0b run_last=%0b end=%0b good=%0b",
                         r.out_byte, r.byte_present, r.run_last, r.frame_end, r.frame_good);
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= SHOWN_ERRORS)
            $display("tb_top: reply %0d: %s", replies, msg);
    endfunction

    function void check_reply(out_rsp_t got);
        out_rsp_t want;
        replies++;
        if (expected_q.size() == 0)
        begin
            flag({"unexpected result ", show(got)});
            return;
        end
        want = expected_q.pop_front();
        if (got.out_byte !== want.out_byte || got.byte_present !== want.byte_present ||
            got.run_last !== want.run_last || got.frame_end !== want.frame_end ||
            got.frame_good !== want.frame_good)
            flag({"expected ", show(want), " got ", show(got)});
    endfunction
endclass

module tb_top;
    typedef enum {FR_GOOD, FR_OPCODE, FR_NO_QUESTION, FR_LONG_LABEL, FR_TRUNCATED,
                  FR_WRONG_QTYPE} frame_kind_e;

    // idle cycles waited after the replies drain, before any register write
    localparam int SETTLE_CYCLES = 8;
    // far above the longest quiet stretch of a correct run (answer burst under stalls)
    localparam int STALL_LIMIT   = 2000;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_req_t     in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_rsp_t    out_data;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = REG_IPV4_ADDRESS;
    logic [31:0] cfg_data = '0;

    int          src_idle = 0;
    int          sink_idle = 0;
    int          bytes_sent = 0;
    logic [7:0]  frame_q[$];

    reply_scoreboard sb = new();

    dns_a_query_redirect_responder_top #(
        .MAX_PACKET_BYTES (MAX_BYTES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= sink_idle);

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            sb.note_request(in_data);
        if (out_valid && out_ready)
            sb.check_reply(out_data);
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    task automatic add_header(logic [7:0] flags_hi, bit no_question);
        logic [7:0] qd_hi;
        logic [7:0] qd_lo;
        qd_hi = 8'($urandom_range(1, 255));
        qd_lo = 8'($urandom_range(1, 255));
        case ($urandom_range(0, 2))
            0: qd_lo = 8'h00;
            1: qd_hi = 8'h00;
            default: ;
        endcase
        if (no_question)
        begin
            qd_hi = 8'h00;
            qd_lo = 8'h00;
        end
        frame_q.delete();
        frame_q.push_back(8'($urandom_range(0, 255)));
        frame_q.push_back(8'($urandom_range(0, 255)));
        frame_q.push_back(flags_hi);
        frame_q.push_back(8'($urandom_range(0, 255)));
        frame_q.push_back(qd_hi);
        frame_q.push_back(qd_lo);
        // answer/authority/additional counts are rewritten, so any value will do
        repeat (6) frame_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_label(int len);
        frame_q.push_back(8'(len));
        repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // name of exactly 'total' bytes, terminator included; total is never 2
    task automatic add_name(int total);
        int r;
        int l;
        r = total;
        while (r > 1)
        begin
            l = $urandom_range(1, (r - 2 > LONGEST_LABEL) ? LONGEST_LABEL : r - 2);
            if (r - l - 1 == 2)
                l = (l > 1) ? l - 1 : l + 1;
            add_label(l);
            r = r - l - 1;
        end
        frame_q.push_back(8'h00);
    endtask

    task automatic add_qtype();
        frame_q.push_back(8'h00);
        frame_q.push_back(8'h01);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'h01);
    endtask

    task automatic build_frame(frame_kind_e kind, int name_len);
        logic [7:0] flags;
        int         idx;
        int         cut;
        flags = 8'($urandom_range(0, 255)) & ~OPCODE_BITS;
        if (kind == FR_OPCODE)
            flags = flags | (8'h08 << $urandom_range(0, 3));
        add_header(flags, kind == FR_NO_QUESTION);
        if (kind == FR_LONG_LABEL)
        begin
            if ($urandom_range(0, 1) == 1)
                add_label($urandom_range(1, LONGEST_LABEL));
            frame_q.push_back(8'($urandom_range(LONGEST_LABEL + 1, 255)));
            repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            add_name(name_len);
            add_qtype();
            if (kind == FR_WRONG_QTYPE)
            begin
                idx = frame_q.size() - 1 - $urandom_range(0, 3);
                frame_q[idx] = frame_q[idx] ^ 8'($urandom_range(1, 255));
            end
            if (kind == FR_TRUNCATED)
            begin
                cut = $urandom_range(1, frame_q.size() - 1);
                while (frame_q.size() > cut)
                    frame_q.delete(frame_q.size() - 1);
            end
            else if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // hold_at >= 0: before that byte, stop and wait for all replies to drain
    task automatic send_frame(int hold_at);
        in_req_t req;
        for (int i = 0; i < frame_q.size(); i++)
        begin
            if (i == hold_at)
            begin
                in_valid <= 1'b0;
                do @(posedge clk); while (sb.pending() != 0);
            end
            req.in_byte = frame_q[i];
            req.in_last = (i == frame_q.size() - 1);
            while ($urandom_range(0, 99) < src_idle)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= req;
            do @(posedge clk); while (!in_ready);
            bytes_sent++;
        end
    endtask

    task automatic random_frames(int budget, bit with_hold);
        int          start;
        int          roll;
        int          name_len;
        bit          hold;
        frame_kind_e kind;
        start = bytes_sent;
        hold  = with_hold;
        while (bytes_sent - start < budget)
        begin
            roll = $urandom_range(0, 99);
            kind = (roll < 60) ? FR_GOOD :
                   (roll < 68) ? FR_OPCODE :
                   (roll < 75) ? FR_NO_QUESTION :
                   (roll < 83) ? FR_LONG_LABEL :
                   (roll < 92) ? FR_TRUNCATED : FR_WRONG_QTYPE;
            name_len = $urandom_range(2, 24);
            if (name_len == 2)
                name_len = 1;
            build_frame(kind, name_len);
            send_frame(hold ? frame_q.size() / 2 : -1);
            hold = 1'b0;
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(logic [31:0] addr, bit valid);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_IPV4_ADDRESS;
        cfg_data  <= addr;
        @(posedge clk);
        cfg_index <= REG_ADDRESS_VALID;
        cfg_data  <= {31'd0, valid};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_register(REG_IPV4_ADDRESS, addr);
        sb.set_register(REG_ADDRESS_VALID, {31'd0, valid});
        @(posedge clk);
    endtask

    initial
    begin
        src_idle  = 20;
        sink_idle = 57;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // address still unset after reset: a clean query must be refused
        build_frame(FR_GOOD, 1);
        send_frame(-1);
        settle();
        configure(32'hFFFF_FFFF, 1'b1);

        add_header(8'h01, 1'b0);
        add_label(LONGEST_LABEL);
        frame_q.push_back(8'h00);
        add_qtype();
        send_frame(-1);
        frame_q.delete();
        frame_q.push_back(8'hFF);
        send_frame(-1);
        build_frame(FR_OPCODE, 3);
        send_frame(-1);
        build_frame(FR_NO_QUESTION, 3);
        send_frame(-1);
        build_frame(FR_LONG_LABEL, 1);
        send_frame(-1);
        build_frame(FR_TRUNCATED, 5);
        send_frame(-1);
        build_frame(FR_WRONG_QTYPE, 1);
        send_frame(-1);

        settle();
        configure(32'h0000_0000, 1'b1);
        src_idle  = 57;
        sink_idle = 20;
        random_frames(1, 1'b1);

        settle();
        configure($urandom, 1'b1);
        src_idle  = 0;
        sink_idle = 0;
        random_frames(1, 1'b0);
        settle();
        configure($urandom, 1'b0);
        random_frames(1, 1'b0);

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule
